[hdl/sdr_pkg.sv]
// Shared types, constants and response tables for the SD SPI-mode responder.
package sdr_pkg;
	localparam int SECTOR_BYTES = 512;
	localparam int IDX_W = $clog2(SECTOR_BYTES);

	localparam logic [7:0] BYTE_IDLE = 8'hFF;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] TOKEN_MULTI = 8'hFC;
	localparam logic [7:0] TOKEN_STOP = 8'hFD;
	localparam logic [7:0] STATUS_OK = 8'h05;
	localparam logic [7:0] STATUS_FAIL = 8'h00;

	localparam logic [6:0] CMD_GO_IDLE = 7'd0;
	localparam logic [6:0] CMD_IF_COND = 7'd8;
	localparam logic [6:0] CMD_STOP = 7'd12;
	localparam logic [6:0] CMD_BLOCKLEN = 7'd16;
	localparam logic [6:0] CMD_READ_ONE = 7'd17;
	localparam logic [6:0] CMD_READ_MANY = 7'd18;
	localparam logic [6:0] CMD_WRITE_ONE = 7'd24;
	localparam logic [6:0] CMD_WRITE_MANY = 7'd25;
	localparam logic [6:0] CMD_APP = 7'd55;
	localparam logic [6:0] CMD_READ_OCR = 7'd58;
	localparam logic [6:0] ACMD_OP_COND = 7'd41;

	localparam logic [0:0] REG_CARD_PRESENT = 1'd0;
	localparam logic [0:0] REG_HIGH_CAPACITY = 1'd1;

	typedef enum logic [11:0] {
		PH_IDLE = 12'b000000000001,
		PH_PARSE = 12'b000000000010,
		PH_R1_IDLE = 12'b000000000100,
		PH_CMD8 = 12'b000000001000,
		PH_CMD12 = 12'b000000010000,
		PH_R1_OK = 12'b000000100000,
		PH_OCR_HC = 12'b000001000000,
		PH_OCR_SC = 12'b000010000000,
		PH_RD_SINGLE = 12'b000100000000,
		PH_RD_MULTI = 12'b001000000000,
		PH_WR_FIRST = 12'b010000000000,
		PH_WR_BODY = 12'b100000000000
	} phase_t;

	typedef struct packed {
		logic func;
		logic [7:0] spi_in;
		logic transfer_start;
		logic [8:0] load_index;
		logic [7:0] load_byte;
		logic store_fail;
	} req_t;

	typedef struct packed {
		logic [7:0] spi_out;
		logic read_request;
		logic write_valid;
		logic [8:0] write_offset;
		logic [7:0] write_data;
		logic commit_request;
		logic [31:0] sector_number;
	} rsp_t;

	// Buffer access between the controller and the sector buffer.
	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [7:0] wr_data;
	} buf_ctl_t;

	// Result fields not taken from the buffer, plus a select for the buffer byte.
	typedef struct packed {
		logic use_buf;
		rsp_t rsp;
	} pend_t;

	// Fixed response byte for a phase at a given position.
	function automatic logic [7:0] fixed_seq(phase_t ph, logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (ph)
			PH_R1_IDLE: r = 8'h01;
			PH_CMD8: begin
				case (i)
					3'd0: r = 8'h01;
					3'd3: r = 8'h01;
					3'd4: r = 8'hAA;
					default: r = 8'h00;
				endcase
			end
			PH_CMD12: r = (i == 3'd0) ? 8'h01 : 8'hFF;
			PH_OCR_HC: r = (i == 3'd1) ? 8'h40 : 8'h00;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] fixed_last(phase_t ph);
		logic [2:0] r;
		case (ph)
			PH_CMD8: r = 3'd4;
			PH_CMD12: r = 3'd7;
			PH_OCR_HC: r = 3'd4;
			PH_OCR_SC: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction
endpackage

[hdl/sdr_stream_if.sv]
// Valid/ready channel carrying one request or result.
interface sdr_stream_if #(type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/sdr_buffer.sv]
// Sector buffer memory, one write and one registered read port.
module sdr_buffer (
	input logic clk,
	input sdr_pkg::buf_ctl_t ctl,
	output logic [7:0] rd_data
);
	import sdr_pkg::*;
	logic [7:0] mem [SECTOR_BYTES];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end
endmodule

[hdl/sdr_ctrl.sv]
// Command parser and transfer sequencer: one request per cycle while fire is high.
module sdr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input sdr_pkg::req_t req,
	input logic card_present,
	input logic high_capacity,
	output sdr_pkg::buf_ctl_t buf_ctl,
	output sdr_pkg::pend_t pend
);
	import sdr_pkg::*;

	phase_t phase_q, phase_d;
	logic [7:0] cmd_q [6];
	logic [7:0] cmd_d [6];
	logic [2:0] cnt_q, cnt_d;
	logic app_q, app_d;
	logic restart_q, restart_d;
	logic [31:0] sector_q, sector_d;
	logic [9:0] bi_q, bi_d;
	logic [2:0] ri_q, ri_d;
	logic multi_q, multi_d;
	logic [7:0] v;
	logic [7:0] cmd;
	logic [31:0] arg;
	logic [7:0] c [6];
	logic [2:0] last;
	logic [9:0] rd_off;

	assign v = req.spi_in;

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		cnt_d = cnt_q;
		app_d = app_q;
		restart_d = restart_q;
		sector_d = sector_q;
		bi_d = bi_q;
		ri_d = ri_q;
		multi_d = multi_q;
		pend = '0;
		buf_ctl = '0;
		c = cmd_q;
		cmd = 8'd0;
		arg = 32'd0;
		last = 3'd0;
		rd_off = 10'd0;

		if (req.func) begin
			buf_ctl.wr_en = 1'b1;
			buf_ctl.wr_addr = req.load_index;
			buf_ctl.wr_data = req.load_byte;
		end else if (!card_present) begin
			pend.rsp.spi_out = BYTE_IDLE;
		end else if (req.transfer_start || restart_q || phase_q == PH_IDLE) begin
			restart_d = 1'b0;
			phase_d = PH_PARSE;
			cmd_d[0] = v;
			cnt_d = (v != BYTE_IDLE) ? 3'd1 : 3'd0;
			pend.rsp.spi_out = TOKEN_START;
		end else begin
			case (phase_q)
				PH_PARSE: begin
					pend.rsp.spi_out = TOKEN_START;
					if (cnt_q != 3'd0 || v != BYTE_IDLE) begin
						if (cnt_q < 3'd6) begin
							c[cnt_q] = v;
						end
						cnt_d = cnt_q + 3'd1;
					end
					cmd_d = c;
					if (cnt_d == 3'd6) begin
						cmd = c[0] & 8'hBF;
						arg = {c[1], c[2], c[3], c[4]};
						if (!high_capacity) begin
							arg = arg >> 9;
						end
						phase_d = PH_IDLE;
						ri_d = 3'd0;
						if (app_q) begin
							app_d = 1'b0;
							if (cmd == {1'b0, ACMD_OP_COND}) begin
								phase_d = PH_R1_OK;
							end
						end else begin
							case (cmd)
								{1'b0, CMD_GO_IDLE}: phase_d = PH_R1_IDLE;
								{1'b0, CMD_IF_COND}: if (high_capacity) phase_d = PH_CMD8;
								{1'b0, CMD_STOP}: phase_d = PH_CMD12;
								{1'b0, CMD_BLOCKLEN}: phase_d = PH_R1_OK;
								{1'b0, CMD_READ_ONE}: begin
									sector_d = arg;
									pend.rsp.read_request = 1'b1;
									pend.rsp.sector_number = arg;
									phase_d = PH_RD_SINGLE;
									bi_d = 10'd0;
								end
								{1'b0, CMD_READ_MANY}: begin
									sector_d = arg;
									phase_d = PH_RD_MULTI;
									bi_d = 10'd0;
								end
								{1'b0, CMD_WRITE_ONE}, {1'b0, CMD_WRITE_MANY}: begin
									sector_d = arg;
									multi_d = (cmd == {1'b0, CMD_WRITE_MANY});
									phase_d = PH_WR_FIRST;
									bi_d = 10'd0;
								end
								{1'b0, CMD_APP}: begin
									app_d = 1'b1;
									phase_d = PH_R1_OK;
								end
								{1'b0, CMD_READ_OCR}:
									phase_d = high_capacity ? PH_OCR_HC : PH_OCR_SC;
								default: phase_d = PH_IDLE;
							endcase
						end
					end
				end
				PH_R1_IDLE, PH_CMD8, PH_CMD12, PH_R1_OK, PH_OCR_HC, PH_OCR_SC: begin
					last = fixed_last(phase_q);
					pend.rsp.spi_out = fixed_seq(phase_q, (ri_q < last) ? ri_q : last);
					if (ri_q >= last) begin
						phase_d = PH_IDLE;
					end else begin
						ri_d = ri_q + 3'd1;
					end
				end
				PH_RD_SINGLE: begin
					if (bi_q >= 10'(SECTOR_BYTES + 3)) begin
						phase_d = PH_IDLE;
					end else begin
						bi_d = bi_q + 10'd1;
					end
					if (bi_q == 10'd1) begin
						pend.rsp.spi_out = TOKEN_START;
					end else if (bi_q >= 10'd2 && bi_q < 10'(SECTOR_BYTES + 2)) begin
						rd_off = bi_q - 10'd2;
						pend.use_buf = 1'b1;
					end
				end
				PH_RD_MULTI: begin
					if (bi_q == 10'd0) begin
						bi_d = 10'd1;
					end else if (bi_q == 10'd1) begin
						bi_d = 10'd2;
						pend.rsp.spi_out = BYTE_IDLE;
					end else if (bi_q == 10'd2) begin
						pend.rsp.spi_out = TOKEN_START;
						if (v != BYTE_IDLE) begin
							phase_d = PH_PARSE;
							cmd_d[0] = v;
							cnt_d = 3'd1;
						end else begin
							pend.rsp.read_request = 1'b1;
							pend.rsp.sector_number = sector_q;
							sector_d = sector_q + 32'd1;
							bi_d = 10'd3;
						end
					end else begin
						bi_d = (bi_q >= 10'(SECTOR_BYTES + 4)) ? 10'd2 : bi_q + 10'd1;
						if (bi_q < 10'(SECTOR_BYTES + 3)) begin
							rd_off = bi_q - 10'd3;
							pend.use_buf = 1'b1;
						end
					end
				end
				PH_WR_FIRST: begin
					phase_d = PH_WR_BODY;
					bi_d = 10'd0;
				end
				PH_WR_BODY: begin
					pend.rsp.spi_out = BYTE_IDLE;
					if (bi_q == 10'd0) begin
						if (multi_q) begin
							if (v == TOKEN_MULTI) begin
								bi_d = 10'd1;
							end else if (v == TOKEN_STOP) begin
								phase_d = PH_IDLE;
							end
						end else if (v == TOKEN_START) begin
							bi_d = 10'd1;
						end
					end else if (bi_q <= 10'(SECTOR_BYTES)) begin
						pend.rsp.write_valid = 1'b1;
						pend.rsp.write_offset = 9'(bi_q - 10'd1);
						pend.rsp.write_data = v;
						bi_d = bi_q + 10'd1;
					end else if (bi_q < 10'(SECTOR_BYTES + 3)) begin
						bi_d = bi_q + 10'd1;
					end else if (bi_q == 10'(SECTOR_BYTES + 3)) begin
						bi_d = bi_q + 10'd1;
						pend.rsp.commit_request = 1'b1;
						pend.rsp.sector_number = sector_q;
						pend.rsp.spi_out = req.store_fail ? STATUS_FAIL : STATUS_OK;
					end else begin
						pend.rsp.spi_out = 8'h01;
						if (multi_q) begin
							bi_d = 10'd0;
							sector_d = sector_q + 32'd1;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: begin
					phase_d = PH_PARSE;
					cmd_d[0] = v;
					cnt_d = (v != BYTE_IDLE) ? 3'd1 : 3'd0;
					pend.rsp.spi_out = TOKEN_START;
				end
			endcase
		end
		buf_ctl.rd_en = fire && pend.use_buf;
		buf_ctl.rd_addr = rd_off[IDX_W-1:0];
		buf_ctl.wr_en = fire && buf_ctl.wr_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			for (int i = 0; i < 6; i++) cmd_q[i] <= 8'h00;
			cnt_q <= 3'd0;
			app_q <= 1'b0;
			restart_q <= 1'b1;
			sector_q <= 32'd0;
			bi_q <= 10'd0;
			ri_q <= 3'd0;
			multi_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d;
			cnt_q <= cnt_d;
			app_q <= app_d;
			restart_q <= restart_d;
			sector_q <= sector_d;
			bi_q <= bi_d;
			ri_q <= ri_d;
			multi_q <= multi_d;
		end
	end
endmodule

[hdl/sd_card_spi_mode_responder.sv]
// Top level of the SD SPI-mode card responder.
// The block takes one request per cycle on in_ch and returns one result per
// request on out_ch. A request either exchanges one SPI byte (func 0) or loads
// one sector byte into the internal 512-byte buffer (func 1). Configuration
// registers card_present and high_capacity are written through cfg_we,
// cfg_index and cfg_data, by the user while idle; the block does not enforce.
// The result is registered: a request accepted at one edge has its result valid
// after that edge. Sector-buffer bytes are read from a memory with a
// registered read port that aligns with that result register.
// Throughput is one request per cycle as long as the receiver takes results.
// When out_ch stalls, the result register holds and in_ch ready drops, so
// no request is taken until the held result leaves.
// Reset clears the parser to idle with a restart pending; the buffer content
// is undefined until loaded.
module sd_card_spi_mode_responder (
	input logic clk,
	input logic arst_n,
	sdr_stream_if.sink in_ch,
	sdr_stream_if.source out_ch,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [0:0] cfg_data
);
	import sdr_pkg::*;

	logic card_present_q, high_capacity_q;
	logic fire;
	logic out_valid_q;
	pend_t pend, pend_s1;
	buf_ctl_t buf_ctl;
	logic [7:0] rd_data;
	req_t req;
	rsp_t rsp;

	assign req = in_ch.payload;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_present_q <= 1'b0;
			high_capacity_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARD_PRESENT: card_present_q <= cfg_data[0];
				REG_HIGH_CAPACITY: high_capacity_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sdr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .fire(fire), .req(req),
		.card_present(card_present_q), .high_capacity(high_capacity_q),
		.buf_ctl(buf_ctl), .pend(pend)
	);

	sdr_buffer u_buf (.clk(clk), .ctl(buf_ctl), .rd_data(rd_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_s1 <= pend;
		end
	end

	always_comb begin
		rsp = pend_s1.rsp;
		if (pend_s1.use_buf) begin
			rsp.spi_out = rd_data;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = rsp;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(pend_s1))
		else $error("held result changed under stall");
	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !in_ch.ready)
		else $error("request taken while result stalled");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $countones({rsp.read_request, rsp.write_valid,
		rsp.commit_request}) <= 1)
		else $error("more than one strobe in a result");
endmodule

[tb/sdr_responder_checker.sv]
// Checker for the SD SPI-mode responder: predicts each result and compares it.
module sdr_responder_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input sdr_pkg::req_t in_payload,
	input logic out_valid,
	input logic out_ready,
	input sdr_pkg::rsp_t out_payload,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [0:0] cfg_data,
	output int fail_count,
	output int pending_replies,
	output int checked_replies
);
	import sdr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic present, hc;
	phase_t ph;
	logic [7:0] cmd_b [6];
	logic [2:0] cnt;
	logic app_pend, restart;
	logic [31:0] cur_sec;
	logic [9:0] bidx;
	logic [2:0] ridx;
	logic multi;
	logic [7:0] sector_buf [SECTOR_BYTES];
	rsp_t reply_q [$];

	assign pending_replies = reply_q.size();

	function automatic void begin_parse(logic [7:0] v);
		ph = PH_PARSE;
		cmd_b[0] = v;
		cnt = (v != BYTE_IDLE) ? 3'd1 : 3'd0;
	endfunction

	function automatic logic [31:0] arg_to_sector();
		logic [31:0] s;
		s = {cmd_b[1], cmd_b[2], cmd_b[3], cmd_b[4]};
		return hc ? s : (s >> 9);
	endfunction

	function automatic void decode_command(inout rsp_t o);
		logic [7:0] c;
		c = cmd_b[0] & 8'hBF;
		ph = PH_IDLE;
		ridx = 3'd0;
		if (app_pend) begin
			app_pend = 1'b0;
			if (c == {1'b0, ACMD_OP_COND}) ph = PH_R1_OK;
			return;
		end
		case (c)
			{1'b0, CMD_GO_IDLE}: ph = PH_R1_IDLE;
			{1'b0, CMD_IF_COND}: if (hc) ph = PH_CMD8;
			{1'b0, CMD_STOP}: ph = PH_CMD12;
			{1'b0, CMD_BLOCKLEN}: ph = PH_R1_OK;
			{1'b0, CMD_READ_ONE}: begin
				cur_sec = arg_to_sector();
				o.read_request = 1'b1;
				o.sector_number = cur_sec;
				ph = PH_RD_SINGLE;
				bidx = '0;
			end
			{1'b0, CMD_READ_MANY}: begin
				cur_sec = arg_to_sector();
				ph = PH_RD_MULTI;
				bidx = '0;
			end
			{1'b0, CMD_WRITE_ONE}, {1'b0, CMD_WRITE_MANY}: begin
				cur_sec = arg_to_sector();
				multi = (c == {1'b0, CMD_WRITE_MANY});
				ph = PH_WR_FIRST;
				bidx = '0;
			end
			{1'b0, CMD_APP}: begin
				app_pend = 1'b1;
				ph = PH_R1_OK;
			end
			{1'b0, CMD_READ_OCR}: ph = hc ? PH_OCR_HC : PH_OCR_SC;
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] next_fixed();
		int len;
		int i;
		logic [7:0] seq [8];
		seq = '{default: 8'h00};
		len = 1;
		case (ph)
			PH_R1_IDLE: seq[0] = 8'h01;
			PH_CMD8: begin
				len = 5;
				seq[0] = 8'h01;
				seq[3] = 8'h01;
				seq[4] = 8'hAA;
			end
			PH_CMD12: begin
				len = 8;
				seq = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
			end
			PH_OCR_HC: begin
				len = 5;
				seq[1] = 8'h40;
			end
			PH_OCR_SC: len = 5;
			default: len = 1;
		endcase
		i = (ridx < len) ? int'(ridx) : len - 1;
		if (i + 1 >= len) ph = PH_IDLE;
		else ridx = 3'(i + 1);
		return seq[i];
	endfunction

	function automatic logic [7:0] exchange_byte(logic [7:0] v, inout rsp_t o);
		int bi;
		bi = int'(bidx);
		case (ph)
			PH_PARSE: begin
				if (cnt > 0 || v != BYTE_IDLE) begin
					if (cnt < 6) cmd_b[cnt] = v;
					cnt = cnt + 3'd1;
				end
				if (cnt == 3'd6) decode_command(o);
				return TOKEN_START;
			end
			PH_R1_IDLE, PH_CMD8, PH_CMD12, PH_R1_OK, PH_OCR_HC, PH_OCR_SC:
				return next_fixed();
			PH_RD_SINGLE: begin
				if (bi + 1 >= SECTOR_BYTES + 4) ph = PH_IDLE;
				else bidx = 10'(bi + 1);
				if (bi == 0) return 8'h00;
				if (bi == 1) return TOKEN_START;
				if (bi < SECTOR_BYTES + 2) return sector_buf[bi - 2];
				return 8'h00;
			end
			PH_RD_MULTI: begin
				if (bi == 0) begin
					bidx = 10'd1;
					return 8'h00;
				end
				if (bi == 1) begin
					bidx = 10'd2;
					return BYTE_IDLE;
				end
				if (bi == 2) begin
					if (v != BYTE_IDLE) begin
						begin_parse(v);
						return TOKEN_START;
					end
					o.read_request = 1'b1;
					o.sector_number = cur_sec;
					cur_sec = cur_sec + 32'd1;
					bidx = 10'd3;
					return TOKEN_START;
				end
				if (bi + 1 >= SECTOR_BYTES + 5) bidx = 10'd2;
				else bidx = 10'(bi + 1);
				if (bi < SECTOR_BYTES + 3) return sector_buf[bi - 3];
				return 8'h00;
			end
			PH_WR_FIRST: begin
				ph = PH_WR_BODY;
				bidx = '0;
				return 8'h00;
			end
			PH_WR_BODY: begin
				if (bi == 0) begin
					if (multi) begin
						if (v == TOKEN_MULTI) bidx = 10'd1;
						else if (v == TOKEN_STOP) ph = PH_IDLE;
					end else if (v == TOKEN_START) begin
						bidx = 10'd1;
					end
					return BYTE_IDLE;
				end
				if (bi <= SECTOR_BYTES) begin
					o.write_valid = 1'b1;
					o.write_offset = 9'(bi - 1);
					o.write_data = v;
					bidx = 10'(bi + 1);
					return BYTE_IDLE;
				end
				if (bi < SECTOR_BYTES + 3) begin
					bidx = 10'(bi + 1);
					return BYTE_IDLE;
				end
				if (bi == SECTOR_BYTES + 3) begin
					bidx = 10'(bi + 1);
					o.commit_request = 1'b1;
					o.sector_number = cur_sec;
					return 8'h00;
				end
				if (multi) begin
					bidx = '0;
					cur_sec = cur_sec + 32'd1;
				end else begin
					ph = PH_IDLE;
				end
				return 8'h01;
			end
			default: begin
				begin_parse(v);
				return TOKEN_START;
			end
		endcase
	endfunction

	function automatic rsp_t predict_reply(req_t r);
		rsp_t o;
		o = '0;
		if (r.func) begin
			sector_buf[r.load_index] = r.load_byte;
			return o;
		end
		if (!present) begin
			o.spi_out = BYTE_IDLE;
			return o;
		end
		if (r.transfer_start || restart || ph == PH_IDLE) begin
			restart = 1'b0;
			begin_parse(r.spi_in);
			o.spi_out = TOKEN_START;
			return o;
		end
		o.spi_out = exchange_byte(r.spi_in, o);
		if (o.commit_request) o.spi_out = r.store_fail ? STATUS_FAIL : STATUS_OK;
		return o;
	endfunction

	task automatic compare_reply(rsp_t got);
		rsp_t exp_r;
		exp_r = reply_q.pop_front();
		checked_replies++;
		if (got.spi_out !== exp_r.spi_out) begin
			$error("spi_out: expected %h, got %h", exp_r.spi_out, got.spi_out);
			fail_count++;
		end
		if (got.read_request !== exp_r.read_request) begin
			$error("read_request: expected %b, got %b", exp_r.read_request, got.read_request);
			fail_count++;
		end
		if (got.write_valid !== exp_r.write_valid) begin
			$error("write_valid: expected %b, got %b", exp_r.write_valid, got.write_valid);
			fail_count++;
		end
		if (got.write_offset !== exp_r.write_offset) begin
			$error("write_offset: expected %0d, got %0d", exp_r.write_offset, got.write_offset);
			fail_count++;
		end
		if (got.write_data !== exp_r.write_data) begin
			$error("write_data: expected %h, got %h", exp_r.write_data, got.write_data);
			fail_count++;
		end
		if (got.commit_request !== exp_r.commit_request) begin
			$error("commit_request: expected %b, got %b", exp_r.commit_request,
				got.commit_request);
			fail_count++;
		end
		if (got.sector_number !== exp_r.sector_number) begin
			$error("sector_number: expected %h, got %h", exp_r.sector_number,
				got.sector_number);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		checked_replies = 0;
		present = 1'b0;
		hc = 1'b0;
		ph = PH_IDLE;
		cmd_b = '{default: 8'h00};
		cnt = '0;
		app_pend = 1'b0;
		restart = 1'b1;
		cur_sec = '0;
		bidx = '0;
		ridx = '0;
		multi = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					$error("result with no request waiting: spi_out %h", out_payload.spi_out);
					fail_count++;
				end else begin
					compare_reply(out_payload);
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_CARD_PRESENT) present = cfg_data[0];
				else hc = cfg_data[0];
			end
			if (in_valid && in_ready) reply_q.insert(reply_q.size(), predict_reply(in_payload));
		end
	end

	final begin
		if (reply_q.size() != 0) $error("%0d results never arrived", reply_q.size());
	end
endmodule

[tb/tb_top.sv]
// Testbench top: drives SPI exchanges, sector loads and configuration.
module tb_top;
	import sdr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [0:0] cfg_data = '0;
	logic calm = 1'b0;
	int fail_count, pending_replies, checked_replies;
	int sent = 0;

	sdr_stream_if #(.T(req_t)) req_ch ();
	sdr_stream_if #(.T(rsp_t)) rsp_ch ();

	sd_card_spi_mode_responder u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(req_ch.sink), .out_ch(rsp_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sdr_responder_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_payload(req_ch.payload),
		.out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_payload(rsp_ch.payload),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_replies(pending_replies),
		.checked_replies(checked_replies)
	);

	always #5 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(posedge clk) rsp_ch.ready <= calm || ($urandom_range(99) >= 15);

	task automatic push_request(req_t r);
		if (!calm && $urandom_range(99) < 15) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		@(negedge clk);
		while (!req_ch.ready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic load_byte(int idx, logic [7:0] b);
		req_t r;
		r = req_t'({$urandom, $urandom});
		r.func = 1'b1;
		r.load_index = 9'(idx);
		r.load_byte = b;
		push_request(r);
	endtask

	task automatic spi_byte(logic [7:0] v, logic start = 1'b0);
		req_t r;
		r = req_t'({$urandom, $urandom});
		r.func = 1'b0;
		r.spi_in = v;
		r.transfer_start = start;
		push_request(r);
	endtask

	task automatic idle_bytes(int n);
		repeat (n) spi_byte(BYTE_IDLE, ($urandom_range(99) < 3));
	endtask

	task automatic send_command(logic [7:0] b0, logic [31:0] arg);
		spi_byte(b0, ($urandom_range(99) < 60));
		repeat ($urandom_range(0, 1)) spi_byte(BYTE_IDLE);
		spi_byte(arg[31:24]);
		spi_byte(arg[23:16]);
		spi_byte(arg[15:8]);
		spi_byte(arg[7:0]);
		spi_byte(8'($urandom));
	endtask

	task automatic write_block(logic [7:0] token, logic full);
		repeat ($urandom_range(0, 2)) spi_byte(8'($urandom_range(0, 8'hFB)));
		spi_byte(token);
		if (full) begin
			repeat (SECTOR_BYTES + 4) spi_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(0, 8)) spi_byte(8'($urandom));
		end
	endtask

	task automatic random_sequence();
		logic [6:0] codes [12];
		logic [7:0] b0;
		logic [31:0] arg;
		logic full;
		int pick;
		codes = '{CMD_GO_IDLE, CMD_IF_COND, CMD_STOP, CMD_BLOCKLEN, CMD_READ_ONE,
			CMD_READ_MANY, CMD_WRITE_ONE, CMD_WRITE_MANY, CMD_APP, CMD_READ_OCR,
			ACMD_OP_COND, 7'($urandom)};
		full = ($urandom_range(99) < 8);
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) spi_byte(8'($urandom), 1'($urandom));
			return;
		end
		pick = $urandom_range(0, 11);
		b0 = {1'b0, codes[pick]} | 8'h40;
		if ($urandom_range(19) == 0) b0 = 8'($urandom);
		arg = ($urandom_range(9) == 0) ? $urandom : ($urandom_range(0, 4095) << 9);
		send_command(b0, arg);
		if (b0 == ({1'b0, CMD_READ_ONE} | 8'h40)) begin
			idle_bytes(full ? SECTOR_BYTES + 4 : $urandom_range(1, 12));
		end else if (b0 == ({1'b0, CMD_READ_MANY} | 8'h40)) begin
			idle_bytes(full ? 2 * (SECTOR_BYTES + 3) + 2 : $urandom_range(1, 12));
			if ($urandom_range(1)) spi_byte(8'h40 | {1'b0, CMD_STOP});
		end else if (b0 == ({1'b0, CMD_WRITE_ONE} | 8'h40)) begin
			spi_byte(BYTE_IDLE);
			write_block(TOKEN_START, full);
		end else if (b0 == ({1'b0, CMD_WRITE_MANY} | 8'h40)) begin
			spi_byte(BYTE_IDLE);
			write_block(TOKEN_MULTI, full);
			if (full) write_block(TOKEN_MULTI, 1'($urandom_range(1)));
			spi_byte(TOKEN_STOP);
		end else begin
			idle_bytes($urandom_range(0, 9));
		end
	endtask

	task automatic write_register(logic [0:0] idx, logic val);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_replies != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int count);
		int stop_at;
		stop_at = sent + count;
		while (sent < stop_at) begin
			calm = (sent % 400) > 300;
			random_sequence();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < SECTOR_BYTES; i++) load_byte(i, 8'($urandom));
		idle_bytes(3);
		spi_byte(8'h40 | {1'b0, CMD_GO_IDLE}, 1'b1);

		write_register(REG_CARD_PRESENT, 1'b1);
		write_register(REG_HIGH_CAPACITY, 1'b0);
		send_command(8'h40 | {1'b0, CMD_GO_IDLE}, 32'h0);
		idle_bytes(2);
		send_command(8'h40 | {1'b0, CMD_IF_COND}, 32'h1AA);
		send_command(8'h40 | {1'b0, CMD_APP}, 32'hFFFF_FFFF);
		idle_bytes(1);
		send_command(8'h40 | {1'b0, ACMD_OP_COND}, 32'h4000_0000);
		idle_bytes(2);
		random_phase(300);

		write_register(REG_HIGH_CAPACITY, 1'b1);
		send_command(8'h40 | {1'b0, CMD_READ_OCR}, 32'h0);
		idle_bytes(6);
		random_phase(300);
		for (int i = 0; i < 20; i++) load_byte($urandom_range(0, 511), 8'($urandom));

		write_register(REG_CARD_PRESENT, 1'b0);
		idle_bytes(4);
		write_register(REG_CARD_PRESENT, 1'b1);
		random_phase(40);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_replies != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		$display("Sent %0d requests over card-absent, byte-addressed and block-addressed",
			sent);
		$display("settings; %0d results compared against the prediction.", checked_replies);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
